/* rtl/lht_pkg.sv */
// ============================================================================
// lht_pkg
// Shared types and constants for the LRU handle tracker: event kinds, result
// codes, controller states and the command and status groups between the
// controller and the datapath.
// ============================================================================
`default_nettype none

package lht_pkg;

  // Fixed field widths of the stream beats.
  localparam int SLOT_ID_W = 4;
  localparam int BUSY_W    = 16;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;
  localparam int LIMIT_W   = 5;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 16;

  // Limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Event kinds carried on the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_INTENT = 2'd0,
    KIND_OPENED = 2'd1,
    KIND_CLOSED = 2'd2,
    KIND_USED   = 2'd3
  } kind_t;

  // Result codes carried on the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_ROOM      = 3'd1,
    ST_VICTIM    = 3'd2,
    ST_NO_VICTIM = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat
    logic clr_walk;  // reset the walk address
    logic issue_rd;  // read the next recency entry
    logic finish;    // apply the update and load the result register
  } lht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_needed;  // the event needs a pass over the recency list
    logic walk_last;    // the read being issued is the last live entry
    logic out_free;     // the result register can take a new beat
  } lht_stat_t;

endpackage

`default_nettype wire

/* rtl/lru_handle_tracker.sv */
// ============================================================================
// lru_handle_tracker
// Recency-ordered list of open handle slots with a victim search on intent.
// ============================================================================
// The list runs from the least recently used slot at position 0 to the most
// recently used at the back. Opened appends a slot at the back, closed removes
// it, used moves it to the back, and an intent-to-open beat compares the open
// count with the limit; at or above it, the list is walked from the least
// recent end and the first slot not set in busy_mask is named. One event is
// in work at a time. An event without a walk goes from capture through decode
// to the finish step; an event that walks the list (intent at the limit,
// closed, used) reads one recency RAM entry per cycle through the single read
// port before it finishes. A finished result waits in an output register, and
// the next event is accepted while it waits.
// ============================================================================
`default_nettype none

module lru_handle_tracker import lht_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration: open_limit.
  input  wire logic                  cfg_wen,
  input  wire logic [LIMIT_W-1:0]    cfg_wdata,
  // Event beats.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] slot_id, [19:4] busy_mask
  input  wire logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
  // Result beats.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] victim_slot, [8:4] open_count,
                                                 // [13:9] room_left
  output logic [STATUS_W-1:0]        out_tuser   // [2:0] status
);

  lht_cmd_t  cmd;
  lht_stat_t stat;

  lht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lht_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire

/* rtl/lht_ram.sv */
// ============================================================================
// lht_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
`default_nettype none

module lht_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/lht_ctrl.sv */
// ============================================================================
// lht_ctrl
// Controller for the LRU handle tracker. Sequences capture, decode, the walk
// over the recency list and the final update of one event at a time.
// ============================================================================
`default_nettype none

module lht_ctrl import lht_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire lht_stat_t stat,
  output lht_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_walk = 1'b1;
        state_nxt    = stat.walk_needed ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        // One read per cycle until the last live entry is requested.
        cmd.issue_rd = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last read returns and is handled here.
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lht_datapath.sv */
// ============================================================================
// lht_datapath
// Datapath for the LRU handle tracker: event registers, open bits, live
// count, limit register, the recency RAM with its walk logic, and the
// result register.
// ============================================================================
`default_nettype none

module lht_datapath import lht_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wen,
  input  wire logic [LIMIT_W-1:0]    cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [KIND_W-1:0]     in_tuser,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [STATUS_W-1:0]        out_tuser,
  input  wire lht_cmd_t              cmd,
  output lht_stat_t                  stat
);

  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Event registers (payload, no reset).
  kind_t               kind_r;
  logic [SLOT_ID_W-1:0] slot_r;
  logic [BUSY_W-1:0]   busy_r;

  // Control state.
  logic [LIMIT_W-1:0]  limit_r;
  logic [CNT_W-1:0]    live_r;
  logic [CNT_W-1:0]    live_nxt;
  logic [BUSY_W-1:0]   open_r;
  logic [BUSY_W-1:0]   open_nxt;
  logic [ADDR_W-1:0]   rd_idx_r;
  logic                pend_r;
  logic [ADDR_W-1:0]   pidx_r;
  logic                found_r;
  logic                found_nxt;
  logic [SLOT_ID_W-1:0] victim_r;
  logic [SLOT_ID_W-1:0] victim_nxt;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_ID_W-1:0] out_victim_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [COUNT_W-1:0]  out_room_r;

  // Decode and walk signals.
  logic                slot_ok;
  logic                slot_is_open;
  logic                at_limit;
  logic [CNT_W-1:0]    live_dec;
  logic [ADDR_W-1:0]   pidx_dec;
  logic [SLOT_ID_W-1:0] ram_rdata;
  logic                walk_match;
  logic                shift_we;

  // Finish signals.
  status_t             fin_status;
  logic [SLOT_ID_W-1:0] fin_victim;
  logic                fin_we;
  logic [ADDR_W-1:0]   fin_waddr;
  logic [CMP_W-1:0]    lim_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    room_full;

  // RAM port signals.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SLOT_ID_W-1:0] ram_wdata;

  // Event decode.
  assign slot_ok      = int'(slot_r) < SLOTS;
  assign slot_is_open = open_r[slot_r];
  assign at_limit     = CMP_W'(live_r) >= CMP_W'(limit_r);
  assign live_dec     = live_r - CNT_W'(1);
  assign pidx_dec     = pidx_r - ADDR_W'(1);

  // Status toward the controller.
  always_comb begin
    stat.walk_needed = 1'b0;
    unique case (kind_r)
      KIND_INTENT: stat.walk_needed = at_limit && (live_r != '0);
      KIND_OPENED: stat.walk_needed = 1'b0;
      KIND_CLOSED,
      KIND_USED:   stat.walk_needed = slot_ok && slot_is_open;
      default:     stat.walk_needed = 1'b0;
    endcase
    stat.walk_last = CNT_W'(rd_idx_r) == live_dec;
    stat.out_free  = !out_valid_r || out_tready;
  end

  // Walk: an intent looks for the first entry that is not busy, a close or
  // use looks for the slot and then shifts every later entry one place down.
  assign walk_match = (kind_r == KIND_INTENT) ? !busy_r[ram_rdata] : (ram_rdata == slot_r);
  assign shift_we   = pend_r && found_r && (kind_r != KIND_INTENT);

  always_comb begin
    found_nxt  = found_r;
    victim_nxt = victim_r;
    if (cmd.load) begin
      found_nxt = 1'b0;
    end else if (pend_r && !found_r && walk_match) begin
      found_nxt  = 1'b1;
      victim_nxt = ram_rdata;
    end
  end

  // Final update and result of the event.
  always_comb begin
    fin_status = ST_DONE;
    fin_victim = '0;
    fin_we     = 1'b0;
    fin_waddr  = live_r[ADDR_W-1:0];
    live_nxt   = live_r;
    open_nxt   = open_r;
    unique case (kind_r)
      KIND_INTENT: begin
        if (!at_limit) begin
          fin_status = ST_ROOM;
        end else if (found_r) begin
          fin_status = ST_VICTIM;
          fin_victim = victim_r;
        end else begin
          fin_status = ST_NO_VICTIM;
        end
      end
      KIND_OPENED: begin
        if (!slot_ok || slot_is_open || (live_r >= CNT_W'(SLOTS))) begin
          fin_status = ST_IGNORED;
        end else begin
          fin_we           = 1'b1;
          fin_waddr        = live_r[ADDR_W-1:0];
          live_nxt         = live_r + CNT_W'(1);
          open_nxt[slot_r] = 1'b1;
        end
      end
      KIND_CLOSED: begin
        if (!slot_ok || !slot_is_open || !found_r) begin
          fin_status = ST_IGNORED;
        end else begin
          live_nxt         = live_dec;
          open_nxt[slot_r] = 1'b0;
        end
      end
      KIND_USED: begin
        if (!slot_ok || !slot_is_open || !found_r) begin
          fin_status = ST_IGNORED;
        end else begin
          // The slot goes back in at the most recent end.
          fin_we    = 1'b1;
          fin_waddr = live_dec[ADDR_W-1:0];
        end
      end
      default: begin
        fin_status = ST_IGNORED;
      end
    endcase
  end

  // Free room after the update, saturating at zero.
  assign lim_ext   = CMP_W'(limit_r);
  assign cnt_ext   = CMP_W'(live_nxt);
  assign room_full = (lim_ext > cnt_ext) ? (lim_ext - cnt_ext) : '0;

  // Recency RAM: shift writes during the walk, final write at finish.
  assign ram_we    = shift_we || (cmd.finish && fin_we);
  assign ram_waddr = shift_we ? pidx_dec : fin_waddr;
  assign ram_wdata = shift_we ? ram_rdata : slot_r;

  lht_ram #(
    .WIDTH (SLOT_ID_W),
    .DEPTH (SLOTS)
  ) u_order_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue_rd),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Event capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_t'(in_tuser);
      slot_r <= in_tdata[SLOT_ID_W-1:0];
      busy_r <= in_tdata[SLOT_ID_W +: BUSY_W];
    end
    victim_r <= victim_nxt;
  end

  // Limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wen) begin
      limit_r <= cfg_wdata;
    end
  end

  // List state and walk control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      open_r   <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      pidx_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        live_r <= live_nxt;
        open_r <= open_nxt;
      end
      if (cmd.clr_walk) begin
        rd_idx_r <= '0;
      end else if (cmd.issue_rd) begin
        rd_idx_r <= rd_idx_r + ADDR_W'(1);
      end
      pend_r  <= cmd.issue_rd;
      pidx_r  <= rd_idx_r;
      found_r <= found_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= fin_status;
      out_victim_r <= fin_victim;
      out_count_r  <= COUNT_W'(live_nxt);
      out_room_r   <= COUNT_W'(room_full);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_room_r, out_count_r, out_victim_r};

endmodule

`default_nettype wire

/* rtl/lht_checker.sv */
// ============================================================================
// lht_checker
// Port-level checks for the LRU handle tracker, bound to the top level.
// ============================================================================
`default_nettype none

module lht_checker import lht_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [STATUS_W-1:0]   out_tuser
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // The victim field is zero unless a victim was chosen.
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_VICTIM) |-> (out_tdata[3:0] == 4'd0))
    else $error("victim slot set without a chosen victim");

  // A victim search only happens at the limit, so no room is left.
  a_search_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_VICTIM) || (out_tuser == ST_NO_VICTIM))
      |-> (out_tdata[13:9] == 5'd0))
    else $error("victim search reported with room left");

  // Room available means a nonzero room count.
  a_room_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ROOM) |-> (out_tdata[13:9] != 5'd0))
    else $error("room reported without free room");

  // Only sixteen slot numbers exist, so the open count never exceeds sixteen.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:4] <= 5'd16))
    else $error("open count above slot range");

endmodule

bind lru_handle_tracker lht_checker u_lht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* dv/lht_result_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// lht_result_checker
// Watches the event, result and configuration ports of the LRU handle tracker.
// Every accepted event beat is run through a local recency-list tracker, and
// the predicted result is queued. Every accepted result beat is compared field
// by field with the oldest prediction. Mismatches and unexpected results are
// counted and handed to the testbench top.
// ============================================================================
`default_nettype none

module lht_result_checker import lht_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wen,
  input  wire logic [LIMIT_W-1:0]    cfg_wdata,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [KIND_W-1:0]     in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic [STATUS_W-1:0]   out_tuser,
  output int                         error_count,
  output int                         outstanding
);

  localparam int NUM_SLOTS = 16;
  localparam int REPORT_MAX = 10;

  typedef struct {
    status_t              status;
    logic [SLOT_ID_W-1:0] victim;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   room;
  } tracker_result_t;

  // Local copy of the tracker state.
  logic [SLOT_ID_W-1:0] lru_list [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] is_open;
  int                   live;
  int                   limit;

  tracker_result_t predicted_results [$];

  // Removes the entry at a list position and closes the gap behind it.
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < live; i++) begin
      lru_list[i] = lru_list[i + 1];
    end
    live--;
  endfunction

  // Applies one event to the local state and returns the result it causes.
  function automatic tracker_result_t track_event(kind_t kind, logic [SLOT_ID_W-1:0] slot,
                                                  logic [BUSY_W-1:0] busy);
    tracker_result_t r;
    int pos;
    bit found;
    r.status = ST_DONE;
    r.victim = '0;
    pos = live;
    found = 1'b0;
    case (kind)
      KIND_INTENT: begin
        if (live >= limit) begin
          // Walk from the least recent end for the first slot that may be closed.
          r.status = ST_NO_VICTIM;
          for (int i = 0; i < live; i++) begin
            if (!found && !busy[lru_list[i]]) begin
              found = 1'b1;
              r.status = ST_VICTIM;
              r.victim = lru_list[i];
            end
          end
        end else begin
          r.status = ST_ROOM;
        end
      end
      KIND_OPENED: begin
        if (is_open[slot] || live >= NUM_SLOTS) begin
          r.status = ST_IGNORED;
        end else begin
          lru_list[live] = slot;
          live++;
          is_open[slot] = 1'b1;
        end
      end
      default: begin
        // Closed and used both need the slot's place in the list.
        for (int i = live - 1; i >= 0; i--) begin
          if (lru_list[i] == slot) begin
            pos = i;
          end
        end
        if (!is_open[slot] || pos >= live) begin
          r.status = ST_IGNORED;
        end else begin
          drop_entry(pos);
          if (kind == KIND_USED) begin
            lru_list[live] = slot;
            live++;
          end else begin
            is_open[slot] = 1'b0;
          end
        end
      end
    endcase
    r.count = COUNT_W'(live);
    r.room = (limit > live) ? COUNT_W'(limit - live) : '0;
    return r;
  endfunction

  // Sample all three ports at each rising edge.
  always @(posedge clk) begin
    tracker_result_t want;
    tracker_result_t got;
    if (!rst_n) begin
      is_open = '0;
      live = 0;
      limit = int'(LIMIT_RESET);
      predicted_results.delete();
    end else begin
      if (cfg_wen) begin
        limit = int'(cfg_wdata);
      end

      // Result beat: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.victim = out_tdata[3:0];
        got.count = out_tdata[8:4];
        got.room = out_tdata[13:9];
        if (predicted_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("%0t: result beat with none expected: %s %0d victim %0d count %0d room %0d",
                     $realtime, "status", got.status, got.victim, got.count, got.room);
          end
        end else begin
          want = predicted_results.pop_front();
          if (got.status !== want.status || got.victim !== want.victim ||
              got.count !== want.count || got.room !== want.room) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
              $display("%0t: result mismatch (expected/actual): status %0d/%0d victim %0d/%0d",
                       $realtime, want.status, got.status, want.victim, got.victim);
              $display("    count %0d/%0d room %0d/%0d",
                       want.count, got.count, want.room, got.room);
            end
          end
        end
      end

      // Event beat: predict its result.
      if (in_tvalid && in_tready) begin
        predicted_results.push_back(track_event(kind_t'(in_tuser), in_tdata[3:0],
                                                in_tdata[19:4]));
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench top for the LRU handle tracker.
// Drives a directed sequence over the limit extremes, duplicate and stray
// events and the victim search, then random phases under several limits that
// alternately fill and drain the list. The sender works in bursts, the
// receiver stalls on its own pattern and once holds off long enough to back
// the block up. A separate checker predicts and compares every result beat.
// ============================================================================
`default_nettype none

module tb;
  import lht_pkg::*;

  // Run limit; with gaps, stalls and the long hold-off a clean run stays well
  // under it.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AFTER = 300;
  localparam int PHASE_ITEMS = 100;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  int error_count;
  int outstanding;
  int cycle_count = 0;

  // Slots the stimulus believes open, used to shape well-formed events.
  logic [15:0] open_shadow = '0;
  int burst_left = 8;

  lru_handle_tracker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lht_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one event beat and waits for it to be taken, then paces the bursts.
  task automatic send_event(input kind_t kind, input logic [3:0] slot,
                            input logic [15:0] busy);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, busy, slot};
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_OPENED) begin
      open_shadow[slot] = 1'b1;
    end else if (kind == KIND_CLOSED) begin
      open_shadow[slot] = 1'b0;
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Waits for the block to drain, then writes a new open limit.
  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Picks a slot in the wanted open state, or any slot if there is none.
  function automatic logic [3:0] pick_slot(bit want_open);
    logic [3:0] cands [$];
    for (int s = 0; s < 16; s++) begin
      if (open_shadow[s] == want_open) begin
        cands.push_back(4'(s));
      end
    end
    if (cands.size() == 0) begin
      return 4'($urandom_range(0, 15));
    end
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // One random event, biased toward filling or draining the list.
  task automatic send_random(input bit filling);
    int roll;
    kind_t kind;
    logic [3:0] slot;
    logic [15:0] busy;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      kind = KIND_INTENT;
    end else if (roll < (filling ? 70 : 40)) begin
      kind = KIND_OPENED;
    end else if (roll < (filling ? 85 : 80)) begin
      kind = KIND_CLOSED;
    end else begin
      kind = KIND_USED;
    end
    // Mostly well-formed events, the rest stray or duplicate ones.
    if ($urandom_range(0, 9) < 8 && kind != KIND_INTENT) begin
      slot = pick_slot(kind != KIND_OPENED);
    end else begin
      slot = 4'($urandom_range(0, 15));
    end
    case ($urandom_range(0, 3))
      0: busy = 16'h0000;
      1: busy = 16'hFFFF;
      2: busy = 16'($urandom);
      default: busy = ~(16'($urandom) & 16'($urandom));
    endcase
    send_event(kind, slot, busy);
  endtask

  // Receiver: stalls in stretches of random style, with one long hold-off.
  initial begin
    int style;
    int stretch;
    int out_beats;
    bit held;
    out_beats = 0;
    held = 1'b0;
    forever begin
      if (!held && out_beats >= HOLD_AFTER) begin
        held = 1'b1;
        style = 3;
        stretch = HOLD_CYCLES;
      end else begin
        style = $urandom_range(0, 2);
        stretch = $urandom_range(10, 60);
      end
      for (int c = 0; c < stretch; c++) begin
        @(posedge clk);
        if (out_tvalid && out_tready) begin
          out_beats++;
        end
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (c % 4 == 0);
          default: out_tready <= 1'b0;
        endcase
      end
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lru_handle_tracker verification failed");
    $finish;
  end

  // Reset, stimulus and verdict.
  initial begin
    logic [LIMIT_W-1:0] phase_limit [8];
    phase_limit = '{5'd16, 5'd1, 5'd8, 5'd31, 5'd0, 5'd12, 5'd4, 5'd16};
    phase_limit[7] = 5'($urandom_range(0, 31));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit: empty list, stray close and use, duplicate open.
    send_event(KIND_INTENT, 4'd0, 16'h0000);
    send_event(KIND_CLOSED, 4'd3, 16'h0000);
    send_event(KIND_USED, 4'd5, 16'hFFFF);
    send_event(KIND_OPENED, 4'd0, 16'h0000);
    send_event(KIND_OPENED, 4'd15, 16'h0000);
    send_event(KIND_OPENED, 4'd0, 16'hFFFF);
    send_event(KIND_USED, 4'd0, 16'h0000);
    send_event(KIND_INTENT, 4'd15, 16'h0000);

    // Zero limit: always at the limit, including with an empty list.
    set_limit(5'd0);
    send_event(KIND_INTENT, 4'd0, 16'hFFFF);
    send_event(KIND_INTENT, 4'd0, 16'h0000);
    send_event(KIND_CLOSED, 4'd15, 16'h0000);
    send_event(KIND_CLOSED, 4'd0, 16'h0000);
    send_event(KIND_INTENT, 4'd9, 16'h0000);

    // Small limit: opening past it, busy front entry, reordering by use.
    set_limit(5'd2);
    send_event(KIND_OPENED, 4'd7, 16'h0000);
    send_event(KIND_OPENED, 4'd9, 16'h0000);
    send_event(KIND_OPENED, 4'd4, 16'h0000);
    send_event(KIND_INTENT, 4'd0, 16'h0080);
    send_event(KIND_USED, 4'd7, 16'h0000);
    send_event(KIND_INTENT, 4'd0, 16'h0000);
    send_event(KIND_CLOSED, 4'd9, 16'h0000);

    // Largest limit value, well above the slot count.
    set_limit(5'd31);
    send_event(KIND_INTENT, 4'd0, 16'h0000);

    // Random phases, alternately filling and draining the list.
    for (int p = 0; p < 8; p++) begin
      set_limit(phase_limit[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random(p % 2 == 0);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("lru_handle_tracker verification clean");
    end else begin
      $display("lru_handle_tracker verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
